// File: rtl/wms_pkg.sv
`timescale 1ns / 1ps

package wms_pkg;

  // Window limits and field widths
  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 16;
  localparam int STD_W       = 16;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int SQ_W        = 2 * SAMPLE_W - 1 + $clog2(MAX_WINDOW);
  localparam int SQ_LO_W     = SQ_W / 2;
  localparam int SQ_HI_W     = SQ_W - SQ_LO_W;
  localparam int NN_W        = 2 * CNT_W;
  // Both n*sumsq and sum^2 fit this width
  localparam int DIV_W       = 2 * SUM_W;
  // Radicand: the variance of 16-bit samples stays below 2^30
  localparam int RAD_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  // One closed window handed from the accumulator to the back end
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [CNT_W-1:0]        count;
  } window_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_VAR,
    BK_START_MEAN,
    BK_WAIT_MEAN,
    BK_START_VAR,
    BK_WAIT_VAR,
    BK_SQRT,
    BK_EMIT
  } back_state_e;

endpackage

// File: rtl/wms_front.sv
`timescale 1ns / 1ps

module wms_front import wms_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       is_last_i,
  output logic                       push_o,
  output window_t                    push_data_o,
  input  logic                       push_ready_i
);

  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic [SQ_W-1:0]              sumsq_q, sumsq_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic signed [2*SAMPLE_W-1:0] square;
  logic                         accept;
  logic                         close;

  // Take a sample only when a closed window could be queued
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  // Square and accumulate the incoming sample
  always_comb begin
    square  = sample_i * sample_i;
    sum_d   = sum_q + SUM_W'(sample_i);
    sumsq_d = sumsq_q + SQ_W'(square[2*SAMPLE_W-2:0]);
    count_d = count_q + CNT_W'(1);
  end

  // Close on the flagged sample or on a full window
  assign close = is_last_i || (count_d == CNT_W'(MAX_WINDOW));

  assign push_o            = accept && close;
  assign push_data_o.sum   = sum_d;
  assign push_data_o.sumsq = sumsq_d;
  assign push_data_o.count = count_d;

  // Advance the accumulators, clear them once a window closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
    end else if (accept) begin
      if (close) begin
        sum_q   <= '0;
        sumsq_q <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        sumsq_q <= sumsq_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// File: rtl/wms_queue.sv
`timescale 1ns / 1ps

module wms_queue import wms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  window_t push_data_i,
  output logic    push_ready_o,
  input  logic    pop_i,
  output logic    pop_valid_o,
  output window_t pop_data_o
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  window_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0]   fill_q;
  logic                do_push, do_pop;

  assign push_ready_o = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Store a pushed window
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

endmodule

// File: rtl/wms_div.sv
`timescale 1ns / 1ps

module wms_div import wms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [NN_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  quot_q;
  logic [NN_W-1:0]   rem_q;
  logic [NN_W-1:0]   div_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [NN_W:0]     rem_shift;
  logic [NN_W:0]     rem_sub;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try the divisor
  always_comb begin
    rem_shift = {rem_q, quot_q[DIV_W-1]};
    rem_sub   = rem_shift - {1'b0, div_q};
    fits      = (rem_shift >= {1'b0, div_q});
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

  // Hold operands and shift in one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], fits};
      rem_q  <= fits ? rem_sub[NN_W-1:0] : rem_shift[NN_W-1:0];
    end
  end

  // Count steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/wms_back.sv
`timescale 1ns / 1ps

module wms_back import wms_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  input  window_t                  pop_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [MEAN_W-1:0] mean_value_o,
  output logic [STD_W-1:0]         std_deviation_o,
  output logic [CNT_W-1:0]         sample_count_o
);

  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int ITER_W     = $clog2(SQRT_STEPS);

  back_state_e        state_q, state_d;

  logic               neg_q;
  logic [SUM_W-1:0]   abs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SQ_W-1:0]    sumsq_q;
  logic [NN_W-1:0]    nn_q;
  logic [DIV_W-1:0]   ssq_q;
  logic [DIV_W-1:0]   lo_q;
  logic [DIV_W-1:0]   hi_q;
  logic [DIV_W-1:0]   var_q;
  logic [MEAN_W-1:0]  mean_q;
  logic [RAD_W-1:0]   rad_q;
  logic [RAD_W-1:0]   root_q;
  logic [RAD_W-1:0]   bit_q;
  logic [ITER_W-1:0]  iter_q;

  logic               out_valid_q;
  logic [MEAN_W-1:0]  out_mean_q;
  logic [STD_W-1:0]   out_std_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [NN_W-1:0]    div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;

  logic               emit;
  logic               out_free;
  logic [RAD_W-1:0]   trial;
  logic               trial_fits;

  assign out_free = !out_valid_q || out_ready_i;

  wms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:       if (pop_valid_i) state_d = BK_MUL;
      BK_MUL:        state_d = BK_ADD;
      BK_ADD:        state_d = BK_VAR;
      BK_VAR:        state_d = BK_START_MEAN;
      BK_START_MEAN: state_d = BK_WAIT_MEAN;
      BK_WAIT_MEAN:  if (div_done) state_d = BK_START_VAR;
      BK_START_VAR:  state_d = BK_WAIT_VAR;
      BK_WAIT_VAR:   if (div_done) state_d = BK_SQRT;
      BK_SQRT:       if (iter_q == ITER_W'(SQRT_STEPS - 1)) state_d = BK_EMIT;
      BK_EMIT:       if (out_free) state_d = BK_IDLE;
      default:       state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = var_q;
    div_divisor  = nn_q;
    emit         = 1'b0;
    case (state_q)
      BK_IDLE:       pop_o = pop_valid_i;
      BK_START_MEAN: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(abs_q);
        div_divisor  = NN_W'(cnt_q);
      end
      BK_START_VAR:  div_start = 1'b1;
      BK_EMIT:       emit = out_free;
      default:       ;
    endcase
  end

  // One root digit: try root + bit against the radicand
  always_comb begin
    trial      = root_q + bit_q;
    trial_fits = (rad_q >= trial);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        neg_q   <= pop_data_i.sum[SUM_W-1];
        abs_q   <= pop_data_i.sum[SUM_W-1] ? $unsigned(-pop_data_i.sum)
                                           : $unsigned(pop_data_i.sum);
        cnt_q   <= pop_data_i.count;
        sumsq_q <= pop_data_i.sumsq;
      end
      BK_MUL: begin
        lo_q  <= DIV_W'(cnt_q * sumsq_q[SQ_LO_W-1:0]);
        hi_q  <= DIV_W'(cnt_q * sumsq_q[SQ_W-1:SQ_LO_W]);
        ssq_q <= DIV_W'(abs_q * abs_q);
        nn_q  <= NN_W'(cnt_q * cnt_q);
      end
      BK_ADD:  var_q <= lo_q + (hi_q << SQ_LO_W);
      BK_VAR:  var_q <= (var_q >= ssq_q) ? (var_q - ssq_q) : '0;
      BK_WAIT_MEAN: begin
        if (div_done) begin
          mean_q <= neg_q ? (MEAN_W'(0) - div_quot[MEAN_W-1:0]) : div_quot[MEAN_W-1:0];
        end
      end
      BK_WAIT_VAR: begin
        if (div_done) begin
          rad_q  <= div_quot[RAD_W-1:0];
          root_q <= '0;
          bit_q  <= RAD_W'(1) << (RAD_W - 2);
          iter_q <= '0;
        end
      end
      BK_SQRT: begin
        if (trial_fits) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q  <= bit_q >> 2;
        iter_q <= iter_q + ITER_W'(1);
      end
      default: ;
    endcase
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_mean_q <= mean_q;
      out_std_q  <= root_q[STD_W-1:0];
      out_cnt_q  <= cnt_q;
    end
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mean_value_o    = $signed(out_mean_q);
  assign std_deviation_o = out_std_q;
  assign sample_count_o  = out_cnt_q;

endmodule

// File: rtl/window_mean_stdev.sv
`timescale 1ns / 1ps
// Mean and population standard deviation over windows of Q7.8 samples.
// Input channel: sample_i with is_last_i, valid/ready; one transfer a cycle while in_ready_o is high.
// A window closes on is_last_i or when it reaches MAX_WINDOW samples.
// Output channel: one result per window: mean_value_o (Q7.8, truncated
// toward zero), std_deviation_o (Q8.8, floor of root), sample_count_o.
// The accumulator takes one sample per cycle while the queue has room and
// hands each closed window to a two-entry queue. The back end works one
// window at a time: one load, a split multiply, add and subtract (4), two
// passes of the bit-serial divider (mean, then variance), and 16 root
// steps, then a load into the output register. The accumulator keeps
// taking samples while the back end works; short windows fill the queue,
// and in_ready_o drops until the back end frees an entry.
// While the receiver stalls the result holds in the output register; the
// back end waits with the next result, and the queue and then the input
// back up behind it. Reset clears the accumulators, the queue and the
// result valid; no result is pending afterwards.

module window_mean_stdev import wms_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       is_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [MEAN_W-1:0]   mean_value_o,
  output logic [STD_W-1:0]           std_deviation_o,
  output logic [CNT_W-1:0]           sample_count_o
);

  logic    push;
  logic    push_ready;
  window_t push_data;
  logic    pop;
  logic    pop_valid;
  window_t pop_data;

  wms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .is_last_i    (is_last_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  wms_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  wms_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mean_value_o    (mean_value_o),
    .std_deviation_o (std_deviation_o),
    .sample_count_o  (sample_count_o)
  );

endmodule

// File: rtl/wms_checker.sv
`timescale 1ns / 1ps

module wms_checker import wms_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       is_last_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [MEAN_W-1:0]   mean_value_o,
  input logic [STD_W-1:0]           std_deviation_o,
  input logic [CNT_W-1:0]           sample_count_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_value_o)
      && $stable(std_deviation_o) && $stable(sample_count_o))
    else $error("stalled result changed");

  // A finished window holds between one and MAX_WINDOW samples
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0 && sample_count_o <= CNT_W'(MAX_WINDOW))
    else $error("sample count out of range");

  // The deviation of Q7.8 samples never exceeds half the full scale
  a_std_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> std_deviation_o <= 16'h8000)
    else $error("standard deviation out of range");

  // Drop any pending result once reset has been seen
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind window_mean_stdev wms_checker u_wms_checker (.*);

// File: tb/sv/window_mean_stdev_checker.sv
`timescale 1ns / 1ps

module window_mean_stdev_checker import wms_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       is_last_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [MEAN_W-1:0]   mean_value_i,
  input  logic [STD_W-1:0]           std_deviation_i,
  input  logic [CNT_W-1:0]           sample_count_i,
  output int                         mismatch_count_o,
  output int                         pending_o,
  output int                         windows_checked_o,
  output int                         limit_windows_o
);

  typedef struct {
    logic signed [MEAN_W-1:0] mean_value;
    logic [STD_W-1:0]         std_deviation;
    logic [CNT_W-1:0]         sample_count;
  } window_stats_t;

  // Accumulators of the window currently being filled
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]         acc_squares;
  logic [CNT_W-1:0]        acc_count;

  window_stats_t expected_stats[$];
  int mismatches;
  int windows_checked;
  int limit_windows;

  assign mismatch_count_o  = mismatches;
  assign windows_checked_o = windows_checked;
  assign limit_windows_o   = limit_windows;

  // Mean truncated toward zero and floor of the population deviation
  function automatic window_stats_t window_stats(input logic signed [SUM_W-1:0] total,
                                                 input logic [SQ_W-1:0] squares,
                                                 input logic [CNT_W-1:0] n);
    window_stats_t stats;
    longint total_l;
    longint n_l;
    longint abs_total;
    longint spread;
    longint variance;
    longint root;
    longint trial;
    total_l = total;
    n_l = longint'(n);
    abs_total = (total_l < 0) ? -total_l : total_l;
    spread = n_l * longint'(squares) - abs_total * abs_total;
    if (spread < 0) spread = 0;
    variance = spread / (n_l * n_l);
    // Build the root one bit at a time from the top
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= variance) root = trial;
    end
    stats.mean_value    = MEAN_W'(total_l / n_l);
    stats.std_deviation = STD_W'(root);
    stats.sample_count  = n;
    return stats;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    window_stats_t want;
    longint magnitude;
    if (!rst_ni) begin
      acc_sum         = '0;
      acc_squares     = '0;
      acc_count       = '0;
      expected_stats.delete();
      mismatches      = 0;
      windows_checked = 0;
      limit_windows   = 0;
      pending_o      <= 0;
    end else begin
      // Compare a result transfer with the oldest closed window
      if (out_valid_i && out_ready_i) begin
        if (expected_stats.size() == 0) begin
          $error("result with no window pending: mean %0d std %0d count %0d",
                 mean_value_i, std_deviation_i, sample_count_i);
          mismatches++;
        end else begin
          want = expected_stats.pop_front();
          windows_checked++;
          if (mean_value_i !== want.mean_value) begin
            $error("mean_value: expected %0d, got %0d", want.mean_value, mean_value_i);
            mismatches++;
          end
          if (std_deviation_i !== want.std_deviation) begin
            $error("std_deviation: expected %0d, got %0d",
                   want.std_deviation, std_deviation_i);
            mismatches++;
          end
          if (sample_count_i !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d",
                   want.sample_count, sample_count_i);
            mismatches++;
          end
        end
      end

      // Accumulate a sample transfer; close on the flag or at the size limit
      if (in_valid_i && in_ready_i) begin
        magnitude = (sample_i < 0) ? -longint'(sample_i) : longint'(sample_i);
        acc_sum     = acc_sum + sample_i;
        acc_squares = acc_squares + SQ_W'(magnitude * magnitude);
        acc_count   = acc_count + 1'b1;
        if (is_last_i || acc_count == CNT_W'(MAX_WINDOW)) begin
          if (acc_count == CNT_W'(MAX_WINDOW)) limit_windows++;
          expected_stats.push_back(window_stats(acc_sum, acc_squares, acc_count));
          acc_sum     = '0;
          acc_squares = '0;
          acc_count   = '0;
        end
      end

      pending_o <= expected_stats.size();
    end
  end

endmodule

// File: tb/sv/window_mean_stdev_tb.sv
`timescale 1ns / 1ps

module window_mean_stdev_tb;
  import wms_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = (2 ** (SAMPLE_W - 1)) - 1;

  typedef enum int {
    MIX_WIDE,
    MIX_EXTREME,
    MIX_NARROW
  } sample_mix_e;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_val = '0;
  logic                       is_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [MEAN_W-1:0]   mean_value;
  logic [STD_W-1:0]           std_deviation;
  logic [CNT_W-1:0]           sample_count;

  int mismatches;
  int pending;
  int windows_checked;
  int limit_windows;
  int samples_sent = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  window_mean_stdev uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_i        (sample_val),
    .is_last_i       (is_last),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .mean_value_o    (mean_value),
    .std_deviation_o (std_deviation),
    .sample_count_o  (sample_count)
  );

  window_mean_stdev_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .sample_i          (sample_val),
    .is_last_i         (is_last),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .mean_value_i      (mean_value),
    .std_deviation_i   (std_deviation),
    .sample_count_i    (sample_count),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .windows_checked_o (windows_checked),
    .limit_windows_o   (limit_windows)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold one sample until its transfer, after an optional random gap
  task automatic send_item(input logic signed [SAMPLE_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample_val <= value;
    is_last    <= last;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Drop valid and hold off until every closed window has reported
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_mix_e mix);
    logic signed [SAMPLE_W-1:0] value;
    case (mix)
      MIX_WIDE: begin
        value = SAMPLE_W'($urandom);
      end
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0: value = SAMPLE_MIN;
          1: value = SAMPLE_MAX;
          2: value = '0;
          default: value = -1;
        endcase
      end
      default: begin
        value = SAMPLE_W'(int'($urandom_range(512)) - 256);
      end
    endcase
    return value;
  endfunction

  // Mostly short windows so results come often; some longer ones
  task automatic send_random_window();
    int len;
    sample_mix_e mix;
    len = ($urandom_range(9) == 0) ? $urandom_range(160, 13) : $urandom_range(12, 1);
    mix = sample_mix_e'($urandom_range(2));
    for (int k = 1; k <= len; k++) send_item(pick_sample(mix), k == len);
  endtask

  // Fill a window to the size limit with full-scale samples
  task automatic send_full_window();
    for (int k = 1; k <= MAX_WINDOW; k++) begin
      send_item(($urandom_range(3) == 0) ? SAMPLE_MAX : SAMPLE_MIN,
                (k == MAX_WINDOW) && ($urandom_range(1) == 1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample windows at the extremes and zero
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MIN, 1'b1);
    send_item('0, 1'b1);
    // Mean of -1/2 and -2/3 truncates toward zero
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(-1, 1'b0);
    send_item(-1, 1'b0);
    send_item('0, 1'b1);
    // Constant window gives zero deviation
    repeat (3) send_item(100, 1'b0);
    send_item(100, 1'b1);
    // Full-scale spread and alternating bit patterns
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MIN, 1'b1);
    send_item(16'sh5555, 1'b0);
    send_item(16'shAAAA, 1'b1);
    wait_for_results();

    // Busy sender, sparse receiver
    send_gap_pct = 9;
    recv_stall_pct <= 85;
    while (samples_sent < 180) send_random_window();
    wait_for_results();

    // Sparse sender, busy receiver
    send_gap_pct = 85;
    recv_stall_pct <= 9;
    while (samples_sent < 350) send_random_window();
    wait_for_results();

    // Full rate on both sides, including a window at the size limit
    send_gap_pct = 0;
    recv_stall_pct <= 0;
    send_full_window();
    while (samples_sent < 1400) send_random_window();

    wait_for_results();
    repeat (300) @(posedge clk);

    $display("Sent %0d samples under three idle patterns; %0d windows checked,",
             samples_sent, windows_checked);
    $display("%0d of them closed at the %0d-sample limit", limit_windows, MAX_WINDOW);
    if (mismatches == 0) begin
      $display("window_mean_stdev regression: pass");
    end else begin
      $display("window_mean_stdev regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("window_mean_stdev regression: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/wms_pkg.sv
rtl/wms_front.sv
rtl/wms_queue.sv
rtl/wms_div.sv
rtl/wms_back.sv
rtl/window_mean_stdev.sv
rtl/wms_checker.sv
tb/sv/window_mean_stdev_checker.sv
tb/sv/window_mean_stdev_tb.sv
